@@ design/ggsl_pkg.sv @@
package ggsl_pkg;

    localparam int VEC_W = 20;
    localparam int TOL_W = 16;
    localparam int TRI_W = 5;
    localparam int SEC_W = 7;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic [3:0] coef_t;

    localparam coef_t ZZ = 4'b0000;
    localparam coef_t PA = 4'b0001;
    localparam coef_t PB = 4'b0010;
    localparam coef_t PH = 4'b0011;
    localparam coef_t PG = 4'b0100;
    localparam coef_t PU = 4'b0101;
    localparam coef_t NA = 4'b1001;
    localparam coef_t NB = 4'b1010;
    localparam coef_t NH = 4'b1011;
    localparam coef_t NG = 4'b1100;
    localparam coef_t NU = 4'b1101;

    localparam logic [2:0] MAG_ZERO = 3'd0;
    localparam logic [2:0] MAG_A    = 3'd1;
    localparam logic [2:0] MAG_B    = 3'd2;
    localparam logic [2:0] MAG_H    = 3'd3;
    localparam logic [2:0] MAG_G    = 3'd4;
    localparam logic [2:0] MAG_U    = 3'd5;

    localparam coef_t INV_TAB [10][9] = '{
        '{NB, PH, PA, ZZ, ZZ, NG, NB, NH, PA},
        '{NA, PB, NH, NH, NA, PB, PB, NH, NA},
        '{NG, ZZ, ZZ, PA, NB, NH, PA, NB, PH},
        '{NH, PA, NB, ZZ, NG, ZZ, PH, PA, NB},
        '{NA, NB, NH, NA, NB, PH, PG, ZZ, ZZ},
        '{NB, NH, NA, PA, PB, NH, PH, NA, PB},
        '{PB, NH, PA, ZZ, ZZ, NG, PB, PH, PA},
        '{PA, NB, NH, PH, PA, PB, NB, PH, NA},
        '{PH, NA, NB, ZZ, PG, ZZ, NH, NA, NB},
        '{PB, PH, NA, NH, PA, PB, NA, NB, NH}
    };

    localparam coef_t MID_TAB [10][9] = '{
        '{ZZ, PU, NG, ZZ, NU, NG, NG, ZZ, PU},
        '{NU, PG, ZZ, ZZ, NU, PG, PG, ZZ, NU},
        '{NG, ZZ, NU, PU, NG, ZZ, NG, ZZ, PU},
        '{NU, NG, ZZ, PU, NG, ZZ, ZZ, PU, NG},
        '{NU, NG, ZZ, PG, ZZ, PU, PG, ZZ, NU},
        '{NG, ZZ, NU, PU, PG, ZZ, ZZ, NU, PG},
        '{ZZ, NU, NG, ZZ, PU, NG, PG, ZZ, PU},
        '{PU, NG, ZZ, ZZ, PU, PG, NG, ZZ, NU},
        '{PU, PG, ZZ, NU, PG, ZZ, ZZ, NU, NG},
        '{ZZ, PU, PG, NU, NG, ZZ, PG, ZZ, NU}
    };

    typedef enum logic [1:0] {
        BR_EQ,
        BR_LT,
        BR_GT
    } branch_t;

    typedef struct packed {
        logic             ok;
        logic             fixed;
        logic [TRI_W-1:0] tri_idx;
        logic [2:0]       umb;
    } coarse_t;

    function automatic longint qc(input longint m, input int fb);
        return ((m <<< fb) + 64'sd500000) / 64'sd1000000;
    endfunction

    function automatic logic [1:0] mod3(input logic [2:0] idx);
        logic [2:0] r;
        r = (idx >= 3'd3) ? idx - 3'd3 : idx;
        return r[1:0];
    endfunction

    function automatic logic [TRI_W-1:0] ucomp(input logic [2:0] idx, input logic [2:0] c);
        logic [TRI_W-1:0] base;
        base = '0;
        case (mod3(idx))
            2'd0:
            begin
                case (c)
                    3'd0: base = 5'd9;
                    3'd1: base = 5'd8;
                    3'd2: base = 5'd7;
                    3'd3: base = 5'd12;
                    default: base = 5'd14;
                endcase
            end
            2'd1:
            begin
                case (c)
                    3'd0: base = 5'd1;
                    3'd1: base = 5'd2;
                    3'd2: base = 5'd4;
                    3'd3: base = 5'd5;
                    default: base = 5'd3;
                endcase
            end
            default:
            begin
                case (c)
                    3'd0: base = 5'd16;
                    3'd1: base = 5'd15;
                    3'd2: base = 5'd13;
                    3'd3: base = 5'd18;
                    default: base = 5'd17;
                endcase
            end
        endcase
        if (idx >= 3'd3)
        begin
            base = (base < 5'd10) ? base + 5'd10 : base - 5'd10;
        end
        return base;
    endfunction

    // selector fields per umbrella: v0c0, v1c1, v2c1, v4c4, v0c4
    function automatic logic [1:0] usel(input logic [2:0] idx, input logic [2:0] k);
        logic [1:0] r;
        r = '0;
        case (mod3(idx))
            2'd0:
            begin
                case (k)
                    3'd0: r = 2'd1;
                    3'd1: r = 2'd2;
                    3'd2: r = 2'd0;
                    3'd3: r = 2'd0;
                    default: r = 2'd2;
                endcase
            end
            2'd1:
            begin
                case (k)
                    3'd0: r = 2'd0;
                    3'd1: r = 2'd0;
                    3'd2: r = 2'd2;
                    3'd3: r = 2'd2;
                    default: r = 2'd0;
                endcase
            end
            default:
            begin
                case (k)
                    3'd0: r = 2'd2;
                    3'd1: r = 2'd2;
                    3'd2: r = 2'd0;
                    3'd3: r = 2'd2;
                    default: r = 2'd1;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

@@ design/ggsl_matmul.sv @@
module ggsl_matmul #(
    parameter int FRAC_BITS = ggsl_pkg::FRAC_BITS_DEF
) (
    input  logic                                    clk,
    input  logic signed [ggsl_pkg::VEC_W-1:0]       vec [3],
    input  logic [3:0]                              mat_sel,
    input  logic                                    use_mid,
    input  logic                                    neg,
    output logic signed [FRAC_BITS+23:0]            w_reg [3]
);

    localparam int CW = FRAC_BITS + 2;
    localparam int PW = ggsl_pkg::VEC_W + CW;
    localparam int W  = FRAC_BITS + 24;

    localparam logic signed [CW-1:0] CA = CW'(ggsl_pkg::qc(64'sd190983, FRAC_BITS));
    localparam logic signed [CW-1:0] CB = CW'(ggsl_pkg::qc(64'sd309017, FRAC_BITS));
    localparam logic signed [CW-1:0] CH = CW'(ggsl_pkg::qc(64'sd500000, FRAC_BITS));
    localparam logic signed [CW-1:0] CG = CW'(ggsl_pkg::qc(64'sd618034, FRAC_BITS));
    localparam logic signed [CW-1:0] CU = CW'(ggsl_pkg::qc(64'sd1000000, FRAC_BITS));

    logic signed [W-1:0] w_next [3];

    function automatic logic signed [CW-1:0] coef_val(input ggsl_pkg::coef_t code);
        logic signed [CW-1:0] mag;
        case (code[2:0])
            ggsl_pkg::MAG_A: mag = CA;
            ggsl_pkg::MAG_B: mag = CB;
            ggsl_pkg::MAG_H: mag = CH;
            ggsl_pkg::MAG_G: mag = CG;
            ggsl_pkg::MAG_U: mag = CU;
            default:         mag = '0;
        endcase
        return code[3] ? -mag : mag;
    endfunction

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            logic signed [W-1:0] acc;
            ggsl_pkg::coef_t code;
            logic signed [PW-1:0] prod;
            acc = '0;
            for (int c = 0; c < 3; c++)
            begin
                code = use_mid ? ggsl_pkg::MID_TAB[mat_sel][3*r+c]
                               : ggsl_pkg::INV_TAB[mat_sel][3*r+c];
                prod = coef_val(code) * vec[c];
                acc = acc + W'(prod);
            end
            w_next[r] = neg ? -acc : acc;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

endmodule

@@ design/ggsl_coarse.sv @@
module ggsl_coarse #(
    parameter int FRAC_BITS = ggsl_pkg::FRAC_BITS_DEF
) (
    input  logic signed [FRAC_BITS+23:0] w [3],
    input  logic signed [FRAC_BITS+23:0] thr,
    input  logic                         inc,
    output ggsl_pkg::coarse_t            co,
    output logic signed [FRAC_BITS+23:0] u0,
    output logic signed [FRAC_BITS+23:0] u1
);

    localparam int W = FRAC_BITS + 24;

    logic [2:0] z;
    logic [2:0] pos;
    logic [2:0] ltz;
    logic [1:0] np;
    logic [1:0] nn;
    logic [1:0] zc;
    logic signed [3:0] bal;
    logic signed [W-1:0] wn [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            z[i]   = (w[i] > -thr) && (w[i] < thr);
            pos[i] = !z[i] && (w[i] > 0);
            ltz[i] = !z[i] && (w[i] < 0);
        end
        np  = 2'(pos[0]) + 2'(pos[1]) + 2'(pos[2]);
        zc  = 2'(z[0]) + 2'(z[1]) + 2'(z[2]);
        nn  = 2'd3 - np - zc;
        if (z == 3'b111)
        begin
            nn = 2'd0;
        end
        bal = $signed({2'b00, np}) - $signed({2'b00, nn});

        co.ok      = 1'b1;
        co.fixed   = 1'b0;
        co.tri_idx = '0;
        co.umb     = '0;
        for (int i = 0; i < 3; i++)
        begin
            wn[i] = w[i];
        end

        if (bal == 4'sd3)
        begin
            co.fixed = 1'b1;
        end
        else if (bal == -4'sd3)
        begin
            co.fixed   = 1'b1;
            co.tri_idx = 5'd10;
        end
        else if (bal == 4'sd2)
        begin
            co.fixed = 1'b1;
            co.ok    = inc;
        end
        else if (bal == -4'sd2)
        begin
            co.fixed   = 1'b1;
            co.tri_idx = 5'd10;
            co.ok      = inc;
        end
        else if (bal == -4'sd1)
        begin
            if (zc == 2'd2)
            begin
                co.fixed   = 1'b1;
                co.tri_idx = 5'd10;
                co.ok      = inc;
            end
            co.umb = pos[0] ? 3'd4 : (pos[1] ? 3'd5 : 3'd3);
            for (int i = 0; i < 3; i++)
            begin
                wn[i] = -w[i];
            end
        end
        else
        begin
            if ((bal == 4'sd1) && (zc == 2'd2))
            begin
                co.fixed = 1'b1;
                co.ok    = inc;
            end
            else if (z == 3'b111)
            begin
                co.fixed = 1'b1;
                co.ok    = 1'b0;
            end
            co.umb = ltz[0] ? 3'd1 : (ltz[1] ? 3'd2 : 3'd0);
        end

        case (ggsl_pkg::mod3(co.umb))
            2'd0:
            begin
                u0 = wn[0];
                u1 = wn[1];
            end
            2'd1:
            begin
                u0 = wn[1];
                u1 = wn[2];
            end
            default:
            begin
                u0 = wn[2];
                u1 = wn[0];
            end
        endcase
    end

endmodule

@@ design/geodesic_grid_section_lookup_core.sv @@
// A request's valid bit passes through s1_valid_reg to s6_valid_reg and then done_reg, which drives done.
// Throughput: one request per cycle; busy is never raised.
// Three constant-coefficient matrix-vector stages set the pipeline depth.
// Results appear on done for one cycle; the receiver cannot stall.
// Reset clears the stage valid bits and done, and sets the tolerance (tol_reg) to 1.
module geodesic_grid_section_lookup_core #(
    parameter int FRAC_BITS = ggsl_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [ggsl_pkg::VEC_W-1:0]   vec_x,
    input  logic signed [ggsl_pkg::VEC_W-1:0]   vec_y,
    input  logic signed [ggsl_pkg::VEC_W-1:0]   vec_z,
    input  logic                                inclusive_edges,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ggsl_pkg::TOL_W-1:0]          cfg_data,
    output logic                                done,
    output logic [ggsl_pkg::SEC_W-1:0]          section,
    output logic                                section_valid
);

    localparam int W  = FRAC_BITS + 24;
    localparam int VW = ggsl_pkg::VEC_W;
    localparam int TW = ggsl_pkg::TRI_W;

    logic [ggsl_pkg::TOL_W-1:0] tol_reg;
    logic signed [W-1:0] thr;

    logic signed [VW-1:0] vin [3];

    logic signed [W-1:0] w1 [3];
    logic signed [W-1:0] w2 [3];
    logic signed [W-1:0] w3 [3];

    logic                 s1_valid_reg;
    logic signed [VW-1:0] s1_v_reg [3];
    logic                 s1_inc_reg;

    ggsl_pkg::coarse_t    co_next;
    logic signed [W-1:0]  u0_next;
    logic signed [W-1:0]  u1_next;

    logic                 s2_valid_reg;
    logic signed [VW-1:0] s2_v_reg [3];
    logic                 s2_inc_reg;
    ggsl_pkg::coarse_t    s2_co_reg;
    logic signed [W-1:0]  s2_u0_reg;
    logic signed [W-1:0]  s2_u1_reg;

    logic signed [W-1:0]  d3;
    ggsl_pkg::branch_t    br_next;
    logic [2:0]           cidx_next;

    logic                 s3_valid_reg;
    logic signed [VW-1:0] s3_v_reg [3];
    logic                 s3_inc_reg;
    ggsl_pkg::coarse_t    s3_co_reg;
    ggsl_pkg::branch_t    s3_br_reg;
    logic                 s3_lt_reg;
    logic [TW-1:0]        s3_comp_reg;
    logic [3:0]           sel3;

    logic                 s4_valid_reg;
    logic signed [VW-1:0] s4_v_reg [3];
    logic                 s4_inc_reg;
    ggsl_pkg::coarse_t    s4_co_reg;
    ggsl_pkg::branch_t    s4_br_reg;
    logic                 s4_lt_reg;
    logic [TW-1:0]        s4_comp_reg;

    logic                 ok_next;
    logic [TW-1:0]        tri_next;

    logic                 s5_valid_reg;
    logic signed [VW-1:0] s5_v_reg [3];
    logic                 s5_inc_reg;
    logic                 s5_ok_reg;
    logic [TW-1:0]        s5_tri_reg;
    logic [3:0]           sel5;

    logic                 s6_valid_reg;
    logic                 s6_inc_reg;
    logic                 s6_ok_reg;
    logic [TW-1:0]        s6_tri_reg;

    logic                 sok_next;
    logic [1:0]           sub_next;
    logic [ggsl_pkg::SEC_W-1:0] section_next;

    logic                 done_reg;
    logic [ggsl_pkg::SEC_W-1:0] section_reg;
    logic                 section_valid_reg;

    function automatic logic isz(input logic signed [W-1:0] s, input logic signed [W-1:0] t);
        return (s > -t) && (s < t);
    endfunction

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign thr = signed'({{(W-ggsl_pkg::TOL_W-FRAC_BITS){1'b0}}, tol_reg, {FRAC_BITS{1'b0}}});

    assign vin[0] = vec_x;
    assign vin[1] = vec_y;
    assign vin[2] = vec_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= ggsl_pkg::TOL_W'(1);
        end
        else if (cfg_valid)
        begin
            tol_reg <= cfg_data;
        end
    end

    // stage 1: first inverse matrix
    ggsl_matmul #(.FRAC_BITS(FRAC_BITS)) u_mm_first (
        .clk     (clk),
        .vec     (vin),
        .mat_sel (4'd0),
        .use_mid (1'b0),
        .neg     (1'b0),
        .w_reg   (w1)
    );

    // stage 2: sign balance and umbrella pick
    ggsl_coarse #(.FRAC_BITS(FRAC_BITS)) u_coarse (
        .w   (w1),
        .thr (thr),
        .inc (s1_inc_reg),
        .co  (co_next),
        .u0  (u0_next),
        .u1  (u1_next)
    );

    // stage 3: umbrella branch
    always_comb
    begin
        d3 = s2_u0_reg - s2_u1_reg;
        if (isz(d3, thr))
        begin
            br_next   = ggsl_pkg::BR_EQ;
            cidx_next = 3'd0;
        end
        else if (s2_u1_reg > s2_u0_reg)
        begin
            br_next   = ggsl_pkg::BR_LT;
            cidx_next = 3'd1;
        end
        else
        begin
            br_next   = ggsl_pkg::BR_GT;
            cidx_next = 3'd4;
        end
    end

    // stage 4: second inverse matrix
    assign sel3 = 4'((s3_comp_reg >= TW'(10)) ? s3_comp_reg - TW'(10) : s3_comp_reg);

    ggsl_matmul #(.FRAC_BITS(FRAC_BITS)) u_mm_umb (
        .clk     (clk),
        .vec     (s3_v_reg),
        .mat_sel (sel3),
        .use_mid (1'b0),
        .neg     (s3_comp_reg >= TW'(10)),
        .w_reg   (w2)
    );

    // stage 5: settle the triangle
    always_comb
    begin
        logic [2:0] u;
        logic signed [W-1:0] xa;
        logic signed [W-1:0] xb;
        u        = s4_co_reg.umb;
        ok_next  = 1'b1;
        tri_next = s4_comp_reg;
        xa       = '0;
        xb       = '0;
        if (s4_co_reg.fixed)
        begin
            ok_next  = s4_co_reg.ok;
            tri_next = s4_co_reg.tri_idx;
        end
        else
        begin
            case (s4_br_reg)
                ggsl_pkg::BR_EQ:
                begin
                    xa = w2[ggsl_pkg::usel(u, 3'd0)];
                    if (isz(xa, thr))
                    begin
                        ok_next = s4_inc_reg;
                    end
                    else if (xa < 0)
                    begin
                        ok_next  = s4_inc_reg;
                        tri_next = ggsl_pkg::ucomp(u, s4_lt_reg ? 3'd3 : 3'd2);
                    end
                end
                ggsl_pkg::BR_LT:
                begin
                    xa = w2[ggsl_pkg::usel(u, 3'd1)];
                    xb = w2[ggsl_pkg::usel(u, 3'd2)];
                    if (isz(xa, thr))
                    begin
                        ok_next  = s4_inc_reg;
                        tri_next = ggsl_pkg::ucomp(u, (xa < 0) ? 3'd2 : 3'd1);
                    end
                    else if (xa < 0)
                    begin
                        tri_next = ggsl_pkg::ucomp(u, 3'd2);
                    end
                    else if (isz(xb, thr))
                    begin
                        ok_next  = s4_inc_reg;
                        tri_next = ggsl_pkg::ucomp(u, (xb > 0) ? 3'd1 : 3'd0);
                    end
                    else if (xb < 0)
                    begin
                        tri_next = ggsl_pkg::ucomp(u, 3'd0);
                    end
                end
                default:
                begin
                    xa = w2[ggsl_pkg::usel(u, 3'd3)];
                    xb = w2[ggsl_pkg::usel(u, 3'd4)];
                    if (isz(xa, thr))
                    begin
                        ok_next  = s4_inc_reg;
                        tri_next = ggsl_pkg::ucomp(u, (xa < 0) ? 3'd0 : 3'd4);
                    end
                    else if (xa < 0)
                    begin
                        tri_next = ggsl_pkg::ucomp(u, 3'd0);
                    end
                    else if (isz(xb, thr))
                    begin
                        ok_next  = s4_inc_reg;
                        tri_next = ggsl_pkg::ucomp(u, (xb > 0) ? 3'd4 : 3'd3);
                    end
                    else if (xb < 0)
                    begin
                        tri_next = ggsl_pkg::ucomp(u, 3'd3);
                    end
                end
            endcase
        end
    end

    // stage 6: mid-point matrix
    assign sel5 = 4'((s5_tri_reg >= TW'(10)) ? s5_tri_reg - TW'(10) : s5_tri_reg);

    ggsl_matmul #(.FRAC_BITS(FRAC_BITS)) u_mm_mid (
        .clk     (clk),
        .vec     (s5_v_reg),
        .mat_sel (sel5),
        .use_mid (1'b1),
        .neg     (s5_tri_reg >= TW'(10)),
        .w_reg   (w3)
    );

    // stage 7: subtriangle
    always_comb
    begin
        logic [2:0] z;
        for (int i = 0; i < 3; i++)
        begin
            z[i] = isz(w3[i], thr);
        end
        sok_next = s6_ok_reg && !((z != 3'b000) && !s6_inc_reg);
        if (!z[0] && (w3[0] < 0))
        begin
            sub_next = 2'd3;
        end
        else if (!z[1] && (w3[1] < 0))
        begin
            sub_next = 2'd1;
        end
        else if (!z[2] && (w3[2] < 0))
        begin
            sub_next = 2'd2;
        end
        else
        begin
            sub_next = 2'd0;
        end
        section_next = sok_next ? {s6_tri_reg, sub_next} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            done_reg     <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_v_reg   <= vin;
        s1_inc_reg <= inclusive_edges;

        s2_v_reg   <= s1_v_reg;
        s2_inc_reg <= s1_inc_reg;
        s2_co_reg  <= co_next;
        s2_u0_reg  <= u0_next;
        s2_u1_reg  <= u1_next;

        s3_v_reg    <= s2_v_reg;
        s3_inc_reg  <= s2_inc_reg;
        s3_co_reg   <= s2_co_reg;
        s3_br_reg   <= br_next;
        s3_lt_reg   <= s2_u0_reg < s2_u1_reg;
        s3_comp_reg <= ggsl_pkg::ucomp(s2_co_reg.umb, cidx_next);

        s4_v_reg    <= s3_v_reg;
        s4_inc_reg  <= s3_inc_reg;
        s4_co_reg   <= s3_co_reg;
        s4_br_reg   <= s3_br_reg;
        s4_lt_reg   <= s3_lt_reg;
        s4_comp_reg <= s3_comp_reg;

        s5_v_reg   <= s4_v_reg;
        s5_inc_reg <= s4_inc_reg;
        s5_ok_reg  <= ok_next;
        s5_tri_reg <= tri_next;

        s6_inc_reg <= s5_inc_reg;
        s6_ok_reg  <= s5_ok_reg;
        s6_tri_reg <= s5_tri_reg;

        section_reg       <= section_next;
        section_valid_reg <= sok_next;
    end

    assign done          = done_reg;
    assign section       = section_reg;
    assign section_valid = section_valid_reg;

endmodule

@@ test/geodesic_grid_section_lookup_core_tb.sv @@
`timescale 1ns / 1ps

module geodesic_grid_section_lookup_core_tb;

    localparam int VEC_W = ggsl_pkg::VEC_W;
    localparam int TOL_W = ggsl_pkg::TOL_W;
    localparam int SEC_W = ggsl_pkg::SEC_W;

    localparam int FB = 16;
    localparam longint CA = ((64'sd190983 <<< FB) + 64'sd500000) / 64'sd1000000;
    localparam longint CB = ((64'sd309017 <<< FB) + 64'sd500000) / 64'sd1000000;
    localparam longint CH = ((64'sd500000 <<< FB) + 64'sd500000) / 64'sd1000000;
    localparam longint CG = ((64'sd618034 <<< FB) + 64'sd500000) / 64'sd1000000;
    localparam longint CU = ((64'sd1000000 <<< FB) + 64'sd500000) / 64'sd1000000;

    localparam int K_REQ   = 0;
    localparam int K_CFG   = 1;
    localparam int K_DRAIN = 2;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        int                      kind;
        logic [TOL_W-1:0]        tol;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic signed [VEC_W-1:0] z;
        logic                    inc;
        int                      gap;
    } req_t;

    typedef struct {
        logic [SEC_W-1:0] section;
        logic             valid;
    } sect_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;
    logic                    inclusive_edges;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [TOL_W-1:0]        cfg_data;
    logic                    done;
    logic [SEC_W-1:0]        section;
    logic                    section_valid;

    req_t   pending_q[$];
    sect_t  section_q[$];
    int     errors;
    int     cycles;
    longint tol_model;
    int     gap_cnt;
    int     drain_cnt;

    longint inv_t[10][9];
    longint mid_t[10][9];
    int     umb_comp[3][5];
    int     umb_sel[3][5];

    geodesic_grid_section_lookup_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .vec_x(vec_x),
        .vec_y(vec_y),
        .vec_z(vec_z),
        .inclusive_edges(inclusive_edges),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .done(done),
        .section(section),
        .section_valid(section_valid)
    );

    initial
    begin
        inv_t = '{
            '{-CB, CH, CA, 0, 0, -CG, -CB, -CH, CA},
            '{-CA, CB, -CH, -CH, -CA, CB, CB, -CH, -CA},
            '{-CG, 0, 0, CA, -CB, -CH, CA, -CB, CH},
            '{-CH, CA, -CB, 0, -CG, 0, CH, CA, -CB},
            '{-CA, -CB, -CH, -CA, -CB, CH, CG, 0, 0},
            '{-CB, -CH, -CA, CA, CB, -CH, CH, -CA, CB},
            '{CB, -CH, CA, 0, 0, -CG, CB, CH, CA},
            '{CA, -CB, -CH, CH, CA, CB, -CB, CH, -CA},
            '{CH, -CA, -CB, 0, CG, 0, -CH, -CA, -CB},
            '{CB, CH, -CA, -CH, CA, CB, -CA, -CB, -CH}
        };
        mid_t = '{
            '{0, CU, -CG, 0, -CU, -CG, -CG, 0, CU},
            '{-CU, CG, 0, 0, -CU, CG, CG, 0, -CU},
            '{-CG, 0, -CU, CU, -CG, 0, -CG, 0, CU},
            '{-CU, -CG, 0, CU, -CG, 0, 0, CU, -CG},
            '{-CU, -CG, 0, CG, 0, CU, CG, 0, -CU},
            '{-CG, 0, -CU, CU, CG, 0, 0, -CU, CG},
            '{0, -CU, -CG, 0, CU, -CG, CG, 0, CU},
            '{CU, -CG, 0, 0, CU, CG, -CG, 0, -CU},
            '{CU, CG, 0, -CU, CG, 0, 0, -CU, -CG},
            '{0, CU, CG, -CU, -CG, 0, CG, 0, -CU}
        };
        umb_comp = '{'{9, 8, 7, 12, 14}, '{1, 2, 4, 5, 3}, '{16, 15, 13, 18, 17}};
        umb_sel  = '{'{1, 2, 0, 0, 2}, '{0, 0, 2, 2, 0}, '{2, 2, 0, 2, 1}};
    end

    function automatic bit near_zero(input longint s, input longint thr);
        return s > -thr && s < thr;
    endfunction

    function automatic void xform(input bit mid, input int sel, input longint v0,
                                  input longint v1, input longint v2, input bit neg,
                                  output longint w0, output longint w1, output longint w2);
        longint s[3];
        for (int r = 0; r < 3; r++)
        begin
            if (mid)
                s[r] = mid_t[sel][3*r] * v0 + mid_t[sel][3*r+1] * v1 + mid_t[sel][3*r+2] * v2;
            else
                s[r] = inv_t[sel][3*r] * v0 + inv_t[sel][3*r+1] * v1 + inv_t[sel][3*r+2] * v2;
            if (neg)
                s[r] = -s[r];
        end
        w0 = s[0];
        w1 = s[1];
        w2 = s[2];
    endfunction

    function automatic int umb_tri(input int idx, input int c);
        int base;
        base = umb_comp[idx % 3][c];
        return idx < 3 ? base : (base + 10) % 20;
    endfunction

    function automatic int umbrella_tri(input int idx, input longint v0, input longint v1,
                                        input longint v2, input longint u0, input longint u1,
                                        input bit inc, input longint thr);
        longint w[3];
        longint d;
        longint xa;
        longint xb;
        int     t;
        int     tidx;
        t = idx % 3;
        d = u0 - u1;
        if (d > -thr && d < thr)
        begin
            tidx = umb_tri(idx, 0);
            xform(0, tidx % 10, v0, v1, v2, tidx > 9, w[0], w[1], w[2]);
            xa = w[umb_sel[t][0]];
            if (near_zero(xa, thr))
                return inc ? tidx : -1;
            if (xa < 0)
                return inc ? umb_tri(idx, u0 < u1 ? 3 : 2) : -1;
            return tidx;
        end
        if (u1 > u0)
        begin
            tidx = umb_tri(idx, 1);
            xform(0, tidx % 10, v0, v1, v2, tidx > 9, w[0], w[1], w[2]);
            xa = w[umb_sel[t][1]];
            xb = w[umb_sel[t][2]];
            if (near_zero(xa, thr))
                return inc ? umb_tri(idx, xa < 0 ? 2 : 1) : -1;
            if (xa < 0)
                return umb_tri(idx, 2);
            if (near_zero(xb, thr))
                return inc ? umb_tri(idx, xb > 0 ? 1 : 0) : -1;
            if (xb < 0)
                return umb_tri(idx, 0);
            return tidx;
        end
        tidx = umb_tri(idx, 4);
        xform(0, tidx % 10, v0, v1, v2, tidx > 9, w[0], w[1], w[2]);
        xa = w[umb_sel[t][3]];
        xb = w[umb_sel[t][4]];
        if (near_zero(xa, thr))
            return inc ? umb_tri(idx, xa < 0 ? 0 : 4) : -1;
        if (xa < 0)
            return umb_tri(idx, 0);
        if (near_zero(xb, thr))
            return inc ? umb_tri(idx, xb > 0 ? 4 : 3) : -1;
        if (xb < 0)
            return umb_tri(idx, 3);
        return tidx;
    endfunction

    function automatic int find_tri(input longint v0, input longint v1, input longint v2,
                                    input bit inc, input longint thr);
        longint w[3];
        longint u0;
        longint u1;
        int     zc;
        int     bal;
        int     umb;
        zc = 0;
        bal = 0;
        xform(0, 0, v0, v1, v2, 0, w[0], w[1], w[2]);
        for (int i = 0; i < 3; i++)
        begin
            if (near_zero(w[i], thr))
                zc++;
            else if (w[i] > 0)
                bal++;
            else
                bal--;
        end
        if (bal == 3)
            return 0;
        if (bal == -3)
            return 10;
        if (bal == 2)
            return inc ? 0 : -1;
        if (bal == -2)
            return inc ? 10 : -1;
        if (bal == -1)
        begin
            if (zc == 2)
                return inc ? 10 : -1;
            if (!near_zero(w[0], thr) && w[0] > 0)
                umb = 4;
            else if (!near_zero(w[1], thr) && w[1] > 0)
                umb = 5;
            else
                umb = 3;
            for (int i = 0; i < 3; i++)
                w[i] = -w[i];
        end
        else
        begin
            if (bal == 1 && zc == 2)
                return inc ? 0 : -1;
            if (bal == 0 && zc == 3)
                return -1;
            if (!near_zero(w[0], thr) && w[0] < 0)
                umb = 1;
            else if (!near_zero(w[1], thr) && w[1] < 0)
                umb = 2;
            else
                umb = 0;
        end
        if (umb % 3 == 0)
        begin
            u0 = w[0];
            u1 = w[1];
        end
        else if (umb % 3 == 1)
        begin
            u0 = w[1];
            u1 = w[2];
        end
        else
        begin
            u0 = w[2];
            u1 = w[0];
        end
        return umbrella_tri(umb, v0, v1, v2, u0, u1, inc, thr);
    endfunction

    function automatic sect_t predict_section(input logic signed [VEC_W-1:0] x,
                                              input logic signed [VEC_W-1:0] y,
                                              input logic signed [VEC_W-1:0] z,
                                              input logic inc, input longint tol);
        sect_t  r;
        longint v0;
        longint v1;
        longint v2;
        longint thr;
        longint w[3];
        int     tidx;
        int     sub;
        v0 = x;
        v1 = y;
        v2 = z;
        thr = tol <<< FB;
        r.section = '0;
        r.valid = 1'b0;
        tidx = find_tri(v0, v1, v2, inc, thr);
        if (tidx < 0 || tidx > 19)
            return r;
        xform(1, tidx % 10, v0, v1, v2, tidx > 9, w[0], w[1], w[2]);
        if ((near_zero(w[0], thr) || near_zero(w[1], thr) || near_zero(w[2], thr)) && !inc)
            return r;
        if (!near_zero(w[0], thr) && w[0] < 0)
            sub = 3;
        else if (!near_zero(w[1], thr) && w[1] < 0)
            sub = 1;
        else if (!near_zero(w[2], thr) && w[2] < 0)
            sub = 2;
        else
            sub = 0;
        r.section = SEC_W'(4 * tidx + sub);
        r.valid = 1'b1;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic  n_start;
        logic  n_cfg;
        req_t  r;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_valid <= 1'b0;
            cfg_data <= '0;
            vec_x <= '0;
            vec_y <= '0;
            vec_z <= '0;
            inclusive_edges <= 1'b0;
            tol_model = 1;
            gap_cnt = 0;
            drain_cnt = 0;
        end
        else
        begin
            n_start = start;
            n_cfg = cfg_valid;
            if (start && !busy)
            begin
                section_q.push_back(predict_section(vec_x, vec_y, vec_z, inclusive_edges,
                                                    tol_model));
                n_start = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                tol_model = cfg_data;
                n_cfg = 1'b0;
            end
            if (!n_start && !n_cfg && pending_q.size() > 0)
            begin
                r = pending_q[0];
                case (r.kind)
                    K_DRAIN:
                    begin
                        if (section_q.size() == 0)
                        begin
                            if (drain_cnt >= DRAIN_CYCLES)
                            begin
                                void'(pending_q.pop_front());
                                drain_cnt = 0;
                            end
                            else
                                drain_cnt++;
                        end
                        else
                            drain_cnt = 0;
                    end
                    K_CFG:
                    begin
                        void'(pending_q.pop_front());
                        cfg_data <= r.tol;
                        n_cfg = 1'b1;
                    end
                    default:
                    begin
                        if (gap_cnt < r.gap)
                            gap_cnt++;
                        else
                        begin
                            void'(pending_q.pop_front());
                            gap_cnt = 0;
                            vec_x <= r.x;
                            vec_y <= r.y;
                            vec_z <= r.z;
                            inclusive_edges <= r.inc;
                            n_start = 1'b1;
                        end
                    end
                endcase
            end
            start <= n_start;
            cfg_valid <= n_cfg;
        end
    end

    always @(posedge clk)
    begin
        sect_t e;
        if (rst_n && done)
        begin
            if (section_q.size() == 0)
            begin
                errors++;
                $error("unexpected result: section %0d valid %0d", section, section_valid);
            end
            else
            begin
                e = section_q.pop_front();
                if (section !== e.section)
                begin
                    errors++;
                    $error("section: expected %0d, actual %0d", e.section, section);
                end
                if (section_valid !== e.valid)
                begin
                    errors++;
                    $error("section_valid: expected %0d, actual %0d", e.valid, section_valid);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** geodesic_grid_section_lookup_core: FAILED **");
            $finish;
        end
    end

    function automatic logic signed [VEC_W-1:0] rand_comp(input int mode);
        case (mode)
            0: return VEC_W'($urandom);
            1: return VEC_W'($urandom_range(4000) - 2000);
            2: return VEC_W'($urandom_range(130000) - 65000);
            default: return '0;
        endcase
    endfunction

    task automatic add_req(input logic signed [VEC_W-1:0] x, input logic signed [VEC_W-1:0] y,
                           input logic signed [VEC_W-1:0] z, input logic inc, input int gap);
        req_t r;
        r.kind = K_REQ;
        r.tol = '0;
        r.x = x;
        r.y = y;
        r.z = z;
        r.inc = inc;
        r.gap = gap;
        pending_q.push_back(r);
    endtask

    task automatic add_cfg(input logic [TOL_W-1:0] tol);
        req_t r;
        r.kind = K_DRAIN;
        r.tol = '0;
        r.x = '0;
        r.y = '0;
        r.z = '0;
        r.inc = 1'b0;
        r.gap = 0;
        pending_q.push_back(r);
        r.kind = K_CFG;
        r.tol = tol;
        pending_q.push_back(r);
    endtask

    task automatic add_random(input int count);
        logic signed [VEC_W-1:0] a;
        logic signed [VEC_W-1:0] b;
        logic signed [VEC_W-1:0] c;
        int                      mode;
        int                      shape;
        int                      gap;
        bit                      burst;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                burst = $urandom_range(1);
            gap = burst ? 0 : $urandom_range(18);
            mode = $urandom_range(2);
            a = rand_comp(mode);
            b = rand_comp(mode);
            c = rand_comp(mode);
            shape = $urandom_range(7);
            case (shape)
                0: c = '0;
                1: b = a;
                2: c = -a;
                3: begin b = '0; c = '0; end
                default: ;
            endcase
            add_req(a, b, c, $urandom_range(1), gap);
        end
    endtask

    localparam logic signed [VEC_W-1:0] VMAX = 20'sh7FFFF;
    localparam logic signed [VEC_W-1:0] VMIN = 20'sh80000;
    localparam logic signed [VEC_W-1:0] ONE  = 20'sh10000;

    initial
    begin
        errors = 0;
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        vec_x = '0;
        vec_y = '0;
        vec_z = '0;
        inclusive_edges = 1'b0;

        for (int m = 0; m < 2; m++)
        begin
            add_req('0, '0, '0, m[0], 0);
            add_req(VMAX, VMAX, VMAX, m[0], 0);
            add_req(VMIN, VMIN, VMIN, m[0], 1);
            add_req(VMAX, VMIN, '0, m[0], 0);
            add_req(ONE, '0, '0, m[0], 2);
            add_req('0, ONE, '0, m[0], 0);
            add_req('0, '0, ONE, m[0], 0);
            add_req(-ONE, '0, '0, m[0], 3);
            add_req(ONE, ONE, '0, m[0], 0);
            add_req('0, -ONE, ONE, m[0], 0);
            add_req(20'sd1, -20'sd1, 20'sd1, m[0], 0);
        end
        add_random(500);
        add_cfg(16'd0);
        add_req('0, '0, '0, 1'b1, 0);
        add_req('0, '0, '0, 1'b0, 0);
        add_random(200);
        add_cfg(16'hFFFF);
        add_req(VMAX, VMAX, VMIN, 1'b1, 0);
        add_req(VMAX, VMAX, VMIN, 1'b0, 0);
        add_random(200);
        add_cfg(16'd3000);
        add_random(250);
        add_cfg(16'($urandom_range(400)));
        add_random(250);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_q.size() > 0 || start || cfg_valid || section_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("** geodesic_grid_section_lookup_core: PASSED **");
        else
            $display("** geodesic_grid_section_lookup_core: FAILED **");
        $finish;
    end

endmodule
